/* hdl/kli_pkg.sv */
// Keyframe interpolator package: command and status codes, shared types.
// No dependencies.
package kli_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_EXACT  = 3'd1,
    ST_INTERP = 3'd2,
    ST_NODATA = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  localparam logic signed [31:0] FULL_TURN = 32'sd23592960;
  localparam int VAL_W = 32;
  localparam int NUM_W = 50;
  localparam int DEN_W = 18;

  typedef struct packed {
    logic start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

/* hdl/kli_divider.sv */
// Restoring divider, one quotient bit per cycle, floor semantics.
// Depends on kli_pkg.
module kli_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  kli_pkg::div_req_t req,
  output kli_pkg::div_rsp_t rsp
);

  localparam int NW = kli_pkg::NUM_W;
  localparam int DW = kli_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;
  logic [NW-1:0] mag;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    shifted  = {rem_r[DW-1:0], q_r[NW-1]};
    trial    = shifted - {1'b0, den_r};
    mag      = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.num[NW-1];
      q_nxt    = mag;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = CW'(NW);
    end else if (busy_r) begin
      if (!trial[DW]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // floor for negative: -(q) - (rem != 0)
  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    if (neg_r)
      rsp.quo = -$signed(q_r) - ((rem_r != '0) ? NW'(1) : NW'(0));
    else
      rsp.quo = $signed(q_r);
  end

endmodule

/* hdl/keyframe_lookup_interpolator.sv */
// Keyframe lookup interpolator top level: table memory, scan and lerp sequencer.
// Depends on kli_pkg and kli_divider.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | command, frame_number, key_*
//  out_    | out | out_valid/out_stall| status, out_tx..out_sy
//
// Clear and append go from idle to the output state. A query scans every entry, then on an exact
// match reads out the matching row, or fetches the two neighbouring rows and runs 5 interpolations,
// each through the 50-step divider, and wraps the rotation lane.
// Synchronous active-low reset empties the table; the memory holds no reset.
// in_stall is high while an item is in work or a result waits for transfer.
module keyframe_lookup_interpolator #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_frame_number,
  input  logic signed [31:0] in_key_tx,
  input  logic signed [31:0] in_key_ty,
  input  logic signed [31:0] in_key_rot,
  input  logic signed [31:0] in_key_sx,
  input  logic signed [31:0] in_key_sy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_tx,
  output logic signed [31:0] out_ty,
  output logic signed [31:0] out_rot,
  output logic signed [31:0] out_sx,
  output logic signed [31:0] out_sy
);

  localparam int AW = $clog2(MAX_KEYFRAMES);
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);
  localparam int NW = kli_pkg::NUM_W;
  localparam int DW = kli_pkg::DEN_W;
  localparam int MW = 16 + 5 * 32;
  localparam logic [32:0] TURN_U   = 33'(kli_pkg::FULL_TURN);
  localparam logic [32:0] TURN_OFS = TURN_U * 33'd92;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_FETCH_P, S_FETCH_N, S_FETCH_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_WRAP, S_OUT
  } state_t;

  // one wide memory: id, tx, ty, rot, sx, sy
  logic [MW-1:0] mem [MAX_KEYFRAMES];
  logic [MW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [15:0]   f_r;
  logic          hit_r, hasp_r, hasn_r;
  logic [AW-1:0] ei_r, pi_r, ni_r;
  logic [15:0]   pid_r, nid_r;
  logic [MW-1:0] prow_r, nrow_r;
  logic [2:0]    lane_r;
  logic signed [31:0] res_r [5];
  logic [2:0]    status_r;
  logic          out_valid_r;
  logic [32:0]   rwrap_r;
  logic [2:0]    wstep_r;

  kli_pkg::div_req_t dreq;
  kli_pkg::div_rsp_t drsp;

  kli_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= {in_frame_number, in_key_tx, in_key_ty, in_key_rot, in_key_sx, in_key_sy};
    rd_q <= mem[rd_addr];
  end

  logic accept;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (in_command == kli_pkg::CMD_APPEND) &&
                    (count_r != CW'(MAX_KEYFRAMES));
  assign wr_addr  = count_r[AW-1:0];

  always_comb begin
    unique case (state_r)
      S_FETCH_P: rd_addr = pi_r;
      S_FETCH_N: rd_addr = ni_r;
      S_FETCH_WAIT: rd_addr = ni_r;
      S_SCAN_CMP: rd_addr = hit_r ? ei_r : idx_r[AW-1:0];
      default:   rd_addr = idx_r[AW-1:0];
    endcase
  end

  // lane field select
  function automatic logic signed [31:0] lane_val(input logic [MW-1:0] row,
                                                  input logic [2:0] k);
    logic signed [31:0] v;
    unique case (k)
      3'd0:    v = row[159:128];
      3'd1:    v = row[127:96];
      3'd2:    v = row[95:64];
      3'd3:    v = row[63:32];
      default: v = row[31:0];
    endcase
    return v;
  endfunction

  logic [15:0]        id_q;
  logic signed [32:0] dval;
  logic [16:0]        nn, gg;
  logic signed [NW-1:0] prod;
  logic signed [32:0] lerp_sum;
  logic [32:0]        turn_sub;
  logic [32:0]        wrapped;
  assign id_q = rd_q[MW-1:MW-16];
  assign dval = 33'(lane_val(nrow_r, lane_r)) - 33'(lane_val(prow_r, lane_r));
  assign nn   = {1'b0, f_r} - {1'b0, pid_r};
  assign gg   = {1'b0, nid_r} - {1'b0, pid_r};
  assign prod = NW'(dval) * $signed({1'b0, nn}) * NW'(2) + NW'($signed({1'b0, gg}));
  assign lerp_sum = 33'(lane_val(prow_r, lane_r)) + 33'(drsp.quo);
  always_comb begin
    turn_sub = TURN_U << wstep_r;
    wrapped  = (rwrap_r >= turn_sub) ? rwrap_r - turn_sub : rwrap_r;
  end

  always_comb begin
    dreq.start = (state_r == S_DIV_GO);
    dreq.num   = prod;
    dreq.den   = {gg, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          f_r    <= in_frame_number;
          idx_r  <= '0;
          hit_r  <= 1'b0;
          hasp_r <= 1'b0;
          hasn_r <= 1'b0;
          for (int k = 0; k < 5; k++) res_r[k] <= '0;
          status_r <= kli_pkg::ST_DONE;
          unique case (in_command)
            kli_pkg::CMD_CLEAR: begin
              count_r <= '0;
              state_r <= S_OUT;
            end
            kli_pkg::CMD_APPEND: begin
              if (count_r == CW'(MAX_KEYFRAMES)) status_r <= kli_pkg::ST_FULL;
              else count_r <= count_r + 1'b1;
              state_r <= S_OUT;
            end
            kli_pkg::CMD_QUERY: state_r <= (count_r == '0) ? S_SCAN_CMP : S_SCAN_RD;
            default: state_r <= S_OUT;
          endcase
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (idx_r == count_r) begin
            if (hit_r) begin
              state_r <= S_FETCH_WAIT;
              status_r <= kli_pkg::ST_EXACT;
              lane_r <= 3'd7;
            end else if (hasp_r && hasn_r) begin
              status_r <= kli_pkg::ST_INTERP;
              state_r <= S_FETCH_P;
            end else begin
              status_r <= kli_pkg::ST_NODATA;
              state_r <= S_OUT;
            end
          end else begin
            if (id_q == f_r) begin
              hit_r <= 1'b1;
              ei_r  <= idx_r[AW-1:0];
            end
            if (id_q < f_r && (!hasp_r || pid_r < id_q)) begin
              hasp_r <= 1'b1;
              pi_r   <= idx_r[AW-1:0];
              pid_r  <= id_q;
            end
            if (id_q > f_r && (!hasn_r || nid_r > id_q)) begin
              hasn_r <= 1'b1;
              ni_r   <= idx_r[AW-1:0];
              nid_r  <= id_q;
            end
            idx_r   <= idx_r + 1'b1;
            state_r <= (idx_r + 1'b1 == count_r) ? S_SCAN_RD : S_SCAN_RD;
          end
        end
        S_FETCH_P: state_r <= S_FETCH_N;
        S_FETCH_N: begin
          prow_r  <= rd_q;
          state_r <= S_FETCH_WAIT;
          lane_r  <= 3'd0;
        end
        S_FETCH_WAIT: begin
          if (lane_r == 3'd7) begin
            res_r[0] <= rd_q[159:128];
            res_r[1] <= rd_q[127:96];
            res_r[2] <= rd_q[95:64];
            res_r[3] <= rd_q[63:32];
            res_r[4] <= rd_q[31:0];
            state_r  <= S_OUT;
          end else begin
            nrow_r  <= rd_q;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: if (drsp.done) begin
          if (lane_r == 3'd2) begin
            rwrap_r <= 33'(lerp_sum) + TURN_OFS;
            wstep_r <= 3'd7;
            state_r <= S_WRAP;
          end else begin
            res_r[lane_r] <= lerp_sum[31:0];
            if (lane_r == 3'd4) state_r <= S_OUT;
            else begin
              lane_r  <= lane_r + 1'b1;
              state_r <= S_DIV_GO;
            end
          end
        end
        S_WRAP: begin
          rwrap_r <= wrapped;
          if (wstep_r == 3'd0) begin
            res_r[2] <= wrapped[31:0];
            lane_r   <= 3'd3;
            state_r  <= S_DIV_GO;
          end else begin
            wstep_r <= wstep_r - 1'b1;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_tx     = res_r[0];
  assign out_ty     = res_r[1];
  assign out_rot    = res_r[2];
  assign out_sx     = res_r[3];
  assign out_sy     = res_r[4];

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_KEYFRAMES)) else $error("entry count overflow");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.busy |-> (state_r == S_DIV_WAIT)) else $error("divider out of step");

endmodule

/* verif/keyframe_lookup_interpolator_test.sv */
`timescale 1ns / 1ps
// Testbench for keyframe_lookup_interpolator: directed table, then random keyframe
// tables with queries, checked against an in-bench predictor. Depends on kli_pkg and keyframe_lookup_interpolator.
module keyframe_lookup_interpolator_test;

  localparam int DEPTH = 64;
  localparam logic signed [63:0] TURN = 64'sd23592960;

  typedef struct packed {
    logic [2:0] status;
    logic signed [31:0] tx, ty, rot, sx, sy;
  } answer_t;

  typedef struct {
    kli_pkg::cmd_t cmd;
    logic [15:0] frame;
    logic signed [31:0] tx, ty, rot, sx, sy;
    bit known;
    answer_t ans;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_command = kli_pkg::CMD_NOP;
  logic [15:0] in_frame_number = 0;
  logic signed [31:0] in_key_tx = 0, in_key_ty = 0, in_key_rot = 0, in_key_sx = 0;
  logic signed [31:0] in_key_sy = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic signed [31:0] out_tx, out_ty, out_rot, out_sx, out_sy;

  keyframe_lookup_interpolator dut (.*);

  always #4 clk = ~clk;

  logic [15:0] key_id [DEPTH];
  logic signed [63:0] key_val [DEPTH][5];
  int key_count = 0;
  answer_t pending [$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;

  function automatic logic signed [63:0] blend(logic signed [63:0] pv, nv, n, g);
    logic signed [63:0] num, den, q;
    num = 2 * (nv - pv) * n + g;
    den = 2 * g;
    q = num / den;
    if (num % den != 0 && num < 0) q = q - 1;
    return pv + q;
  endfunction

  function automatic answer_t keyframe_answer(kli_pkg::cmd_t cmd, logic [15:0] f,
      logic signed [31:0] a, b, c, d, e);
    answer_t r;
    logic signed [63:0] v [5];
    bit hit, hp, hn;
    int ei, pi, ni;
    logic signed [63:0] n, g, w;
    r = '{kli_pkg::ST_DONE, 0, 0, 0, 0, 0};
    for (int k = 0; k < 5; k++) v[k] = 0;
    hit = 0; hp = 0; hn = 0; ei = 0; pi = 0; ni = 0;
    case (cmd)
      kli_pkg::CMD_CLEAR: key_count = 0;
      kli_pkg::CMD_APPEND: begin
        if (key_count >= DEPTH) r.status = kli_pkg::ST_FULL;
        else begin
          key_id[key_count] = f;
          key_val[key_count][0] = a; key_val[key_count][1] = b;
          key_val[key_count][2] = c; key_val[key_count][3] = d;
          key_val[key_count][4] = e;
          key_count++;
        end
      end
      kli_pkg::CMD_QUERY: begin
        for (int i = 0; i < key_count; i++) begin
          if (key_id[i] == f) begin hit = 1; ei = i; end
          if (key_id[i] < f && (!hp || key_id[pi] < key_id[i])) begin hp = 1; pi = i; end
          if (key_id[i] > f && (!hn || key_id[ni] > key_id[i])) begin hn = 1; ni = i; end
        end
        if (hit) begin
          r.status = kli_pkg::ST_EXACT;
          for (int k = 0; k < 5; k++) v[k] = key_val[ei][k];
        end else if (hp && hn) begin
          r.status = kli_pkg::ST_INTERP;
          n = f - key_id[pi];
          g = key_id[ni] - key_id[pi];
          for (int k = 0; k < 5; k++) v[k] = blend(key_val[pi][k], key_val[ni][k], n, g);
          w = v[2] % TURN;
          if (w < 0) w = w + TURN;
          v[2] = w;
        end else r.status = kli_pkg::ST_NODATA;
      end
      default: ;
    endcase
    r.tx = v[0][31:0]; r.ty = v[1][31:0]; r.rot = v[2][31:0];
    r.sx = v[3][31:0]; r.sy = v[4][31:0];
    return r;
  endfunction

  task automatic send(row_t t);
    answer_t p;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= t.cmd; in_frame_number <= t.frame;
    in_key_tx <= t.tx; in_key_ty <= t.ty; in_key_rot <= t.rot;
    in_key_sx <= t.sx; in_key_sy <= t.sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = keyframe_answer(t.cmd, t.frame, t.tx, t.ty, t.rot, t.sx, t.sy);
    if (t.known && p != t.ans) begin
      $display("%0t predictor disagrees with table row: expected %p got %p", $time, t.ans, p);
      errors++;
    end
    pending.push_back(p);
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (rst_n) out_stall <= ($urandom_range(99) < recv_stall);
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, out_status);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_status != e.status || out_tx != e.tx || out_ty != e.ty ||
            out_rot != e.rot || out_sx != e.sx || out_sy != e.sy) begin
          $display("%0t mismatch: expected %0d %h %h %h %h %h got %0d %h %h %h %h %h",
                   $time, e.status, e.tx, e.ty, e.rot, e.sx, e.sy,
                   out_status, out_tx, out_ty, out_rot, out_sx, out_sy);
          errors++;
        end
      end
    end
  end

  function automatic row_t mk(kli_pkg::cmd_t c, logic [15:0] f,
      logic signed [31:0] v0, v1, v2, v3,
      v4, bit k = 0, logic [2:0] s = 0, logic signed [31:0] o0 = 0, o1 = 0, o2 = 0,
      o3 = 0, o4 = 0);
    row_t r;
    r.cmd = c; r.frame = f; r.tx = v0; r.ty = v1; r.rot = v2; r.sx = v3; r.sy = v4;
    r.known = k; r.ans = '{s, o0, o1, o2, o3, o4};
    return r;
  endfunction

  function automatic logic signed [31:0] rval();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t rnd_row(kli_pkg::cmd_t c, int span);
    return mk(c, (span == 0) ? 16'($urandom) : 16'($urandom_range(span)),
              rval(), rval(), rval(), rval(), rval());
  endfunction

  row_t table_rows [$];
  int sent = 0;

  initial begin
    #2000000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int len, span, q;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    table_rows = '{
      mk(kli_pkg::CMD_QUERY, 16'd5, 0, 0, 0, 0, 0, 1, kli_pkg::ST_NODATA),
      mk(kli_pkg::CMD_NOP, 16'hffff, -1, -1, -1, -1, -1, 1, kli_pkg::ST_DONE),
      mk(kli_pkg::CMD_APPEND, 16'd0, 32'sh80000000, 32'sh7fffffff, -1, 0, 1, 1,
         kli_pkg::ST_DONE),
      mk(kli_pkg::CMD_APPEND, 16'hffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
         32'sh80000000, 32'sh7fffffff, 1, kli_pkg::ST_DONE),
      mk(kli_pkg::CMD_QUERY, 16'd0, 0, 0, 0, 0, 0, 1, kli_pkg::ST_EXACT, 32'sh80000000,
         32'sh7fffffff, -1, 0, 1),
      mk(kli_pkg::CMD_QUERY, 16'h8000, 0, 0, 0, 0, 0),
      mk(kli_pkg::CMD_QUERY, 16'd1, 0, 0, 0, 0, 0),
      mk(kli_pkg::CMD_QUERY, 16'hfffe, 0, 0, 0, 0, 0),
      mk(kli_pkg::CMD_APPEND, 16'd100, 1, 2, -32'sd65536, 4, 5),
      mk(kli_pkg::CMD_APPEND, 16'd100, 6, 7, 32'sd30000000, 9, 10),
      mk(kli_pkg::CMD_QUERY, 16'd100, 0, 0, 0, 0, 0, 1, kli_pkg::ST_EXACT, 6, 7,
         32'sd30000000, 9, 10),
      mk(kli_pkg::CMD_APPEND, 16'd102, 3, 3, 32'sd65536, 3, 3),
      mk(kli_pkg::CMD_APPEND, 16'd102, 9, 9, 9, 9, 9),
      mk(kli_pkg::CMD_QUERY, 16'd101, 0, 0, 0, 0, 0),
      mk(kli_pkg::CMD_QUERY, 16'd50, 0, 0, 0, 0, 0),
      mk(kli_pkg::CMD_CLEAR, 16'd0, 0, 0, 0, 0, 0, 1, kli_pkg::ST_DONE),
      mk(kli_pkg::CMD_QUERY, 16'd100, 0, 0, 0, 0, 0, 1, kli_pkg::ST_NODATA),
      mk(kli_pkg::CMD_APPEND, 16'd10, 0, 0, -32'sd100, 0, 0),
      mk(kli_pkg::CMD_APPEND, 16'd13, 1, -1, -32'sd200, 2, -2),
      mk(kli_pkg::CMD_QUERY, 16'd11, 0, 0, 0, 0, 0),
      mk(kli_pkg::CMD_QUERY, 16'd12, 0, 0, 0, 0, 0)
    };
    foreach (table_rows[i]) send(table_rows[i]);
    for (int i = 0; i < DEPTH; i++) send(rnd_row(kli_pkg::CMD_APPEND, 0));
    send(mk(kli_pkg::CMD_APPEND, 16'd7, 1, 1, 1, 1, 1, 1, kli_pkg::ST_FULL));
    send(rnd_row(kli_pkg::CMD_QUERY, 0));
    send(rnd_row(kli_pkg::CMD_QUERY, 0));
    sent = 0;
    while (sent < 1750) begin
      case ((sent / 100) % 5)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 56; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 56; end
        3: begin send_idle = 14; recv_stall = 14; end
        default: begin send_idle = $urandom_range(30); recv_stall = $urandom_range(30); end
      endcase
      send(mk(kli_pkg::CMD_CLEAR, 16'($urandom), rval(), rval(), rval(), rval(), rval()));
      len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 2) : $urandom_range(1, 8);
      span = ($urandom_range(2) == 0) ? 0 : $urandom_range(4, 60);
      for (int i = 0; i < len; i++) send(rnd_row(kli_pkg::CMD_APPEND, span));
      q = $urandom_range(2, 6);
      for (int i = 0; i < q; i++)
        send(rnd_row($urandom_range(7) == 0 ? kli_pkg::CMD_NOP : kli_pkg::CMD_QUERY, span));
      sent += len + q + 1;
    end
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* sim.f */
hdl/kli_pkg.sv
hdl/kli_divider.sv
hdl/keyframe_lookup_interpolator.sv
verif/keyframe_lookup_interpolator_test.sv
